// File: hw/rtl/fwts_pkg.sv
// ----------------------------------------------------------------------------
// FIFO window tracking set: shared package
// Field widths, operation codes, the micro-step codes and the control store
// of the sequencer that steps through each operation.
// ----------------------------------------------------------------------------
`default_nettype none

package fwts_pkg;

  // Payload widths.
  localparam int TidW   = 22;
  localparam int CountW = 6;
  localparam int OpW    = 2;

  // Default ring size.
  localparam int DefSlotCount = 48;

  // Operation codes.
  localparam logic [OpW-1:0] OP_TRACK   = 2'd0;
  localparam logic [OpW-1:0] OP_UNTRACK = 2'd1;
  localparam logic [OpW-1:0] OP_RELALL  = 2'd2;
  localparam logic [OpW-1:0] OP_NOP     = 2'd3;

  // Micro-step addresses.
  typedef logic [2:0] step_t;
  localparam step_t STEP_CLEAR = 3'd0;
  localparam step_t STEP_IDLE  = 3'd1;
  localparam step_t STEP_START = 3'd2;
  localparam step_t STEP_SCAN  = 3'd3;
  localparam step_t STEP_FIN   = 3'd4;

  // Datapath actions.
  typedef logic [2:0] act_t;
  localparam act_t ACT_CLEAR  = 3'd0;
  localparam act_t ACT_ACCEPT = 3'd1;
  localparam act_t ACT_START  = 3'd2;
  localparam act_t ACT_SCAN   = 3'd3;
  localparam act_t ACT_FINISH = 3'd4;

  // Jump conditions.
  typedef logic [1:0] jc_t;
  localparam jc_t JC_NEXT       = 2'd0;
  localparam jc_t JC_ALWAYS     = 2'd1;
  localparam jc_t JC_DISPATCH   = 2'd2;
  localparam jc_t JC_UNTIL_LAST = 2'd3;

  // One control word of the micro-program.
  typedef struct packed {
    act_t  act;
    jc_t   jc;
    step_t target;
  } uword_t;

  // Status returned from the datapath to the sequencer.
  typedef struct packed {
    logic go;    // a request is taken this cycle
    logic nop;   // the request needs no scan
    logic last;  // the sweep or scan reaches its final slot
    logic hold;  // the datapath cannot complete this step yet
  } ustat_t;

  // Control store.
  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    unique case (s)
      STEP_CLEAR: w = '{act: ACT_CLEAR,  jc: JC_UNTIL_LAST, target: STEP_IDLE};
      STEP_IDLE:  w = '{act: ACT_ACCEPT, jc: JC_DISPATCH,   target: STEP_FIN};
      STEP_START: w = '{act: ACT_START,  jc: JC_NEXT,       target: STEP_SCAN};
      STEP_SCAN:  w = '{act: ACT_SCAN,   jc: JC_UNTIL_LAST, target: STEP_FIN};
      STEP_FIN:   w = '{act: ACT_FINISH, jc: JC_ALWAYS,     target: STEP_IDLE};
      default:    w = '{act: ACT_FINISH, jc: JC_ALWAYS,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fwts_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered under a read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module fwts_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fwts_seq.sv
// ----------------------------------------------------------------------------
// Micro-sequencer
// Step counter over the control store, with dispatch and loop-until-last jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module fwts_seq
  import fwts_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire ustat_t stat,
  output uword_t      ctrl
);

  step_t step_r;
  step_t step_nxt;

  // Current control word.
  assign ctrl = ucode_rom(step_r);

  // Next step selection; a hold keeps the current step.
  always_comb begin
    step_nxt = step_r;
    if (!stat.hold) begin
      unique case (ctrl.jc)
        JC_NEXT:   step_nxt = step_r + step_t'(1);
        JC_ALWAYS: step_nxt = ctrl.target;
        JC_DISPATCH: begin
          if (stat.go) begin
            step_nxt = stat.nop ? ctrl.target : step_r + step_t'(1);
          end
        end
        JC_UNTIL_LAST: begin
          if (stat.last) begin
            step_nxt = ctrl.target;
          end
        end
        default: step_nxt = step_r;
      endcase
    end
  end

  // Reset starts with the clearing sweep of the slot store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_CLEAR;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fifo_window_tracking_set_top.sv
// ----------------------------------------------------------------------------
// FIFO window tracking set
// Ring of thread-id slots with a fill pointer; track, untrack and release all.
// ----------------------------------------------------------------------------
// Track, untrack, release all: the scan reads one slot per cycle through the
// single read port of the slot RAM, save where a stalled output holds a
// release-all scan, and a new request is taken only once the last one is done.
// A result after the scan shows from the finishing step. Release-all releases
// come out during the scan. The unused op skips the scan and answers from the
// finishing step. After reset a clearing pass empties every slot.
`default_nettype none

module fifo_window_tracking_set_top
  import fwts_pkg::*;
#(
  parameter int SLOT_COUNT = DefSlotCount
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [OpW-1:0]    in_op,
  input  wire logic [TidW-1:0]   in_tid,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [TidW-1:0]   out_release_tid,
  output logic                   out_release_valid,
  output logic      [CountW-1:0] out_held_count,
  output logic                   out_last
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int XW = (CW > CountW) ? CW : CountW;

  // Sequencer.
  uword_t ctrl;
  ustat_t stat;

  fwts_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Slot store.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [TidW-1:0] ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [TidW-1:0] ram_rdata;

  fwts_ram #(
    .WIDTH (TidW),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Datapath registers.
  logic [OpW-1:0]  op_r, op_nxt;
  logic [TidW-1:0] tid_r, tid_nxt;
  logic [AW-1:0]   ptr_r, ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   scan_r, scan_nxt;
  logic [AW-1:0]   ev_r, ev_nxt;
  logic            hit_r, hit_nxt;
  logic [TidW-1:0] victim_r, victim_nxt;
  logic            rel_any_r, rel_any_nxt;

  // Result register.
  logic              out_valid_r;
  logic [TidW-1:0]   out_rel_r;
  logic              out_rv_r;
  logic [CountW-1:0] out_held_r;
  logic              out_last_r;

  logic            go;
  logic            out_busy;
  logic            emit;
  logic            hold;
  logic            last;
  logic [TidW-1:0] e_rel;
  logic            e_rv;
  logic [CW-1:0]   e_held;
  logic            e_last;
  logic [XW-1:0]   held_x;

  assign in_stall = (ctrl.act != ACT_ACCEPT);
  assign go       = in_valid && !in_stall;
  assign out_busy = out_valid_r && out_stall;

  assign stat = '{go: go, nop: (in_op == OP_NOP), last: last, hold: hold};

  // Per-step datapath control.
  always_comb begin
    op_nxt      = op_r;
    tid_nxt     = tid_r;
    ptr_nxt     = ptr_r;
    cnt_nxt     = cnt_r;
    scan_nxt    = scan_r;
    ev_nxt      = ev_r;
    hit_nxt     = hit_r;
    victim_nxt  = victim_r;
    rel_any_nxt = rel_any_r;
    ram_we      = 1'b0;
    ram_waddr   = ev_r;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    emit        = 1'b0;
    hold        = 1'b0;
    last        = 1'b0;
    e_rel       = '0;
    e_rv        = 1'b0;
    e_held      = cnt_r;
    e_last      = 1'b1;
    unique case (ctrl.act)
      // Clearing sweep after reset.
      ACT_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = scan_r[AW-1:0];
        last      = (scan_r == CW'(SLOT_COUNT - 1));
        scan_nxt  = last ? '0 : scan_r + CW'(1);
      end
      // Take a request.
      ACT_ACCEPT: begin
        if (go) begin
          op_nxt  = in_op;
          tid_nxt = in_tid;
        end
      end
      // Issue the first read of the scan.
      ACT_START: begin
        ram_re      = 1'b1;
        ram_raddr   = '0;
        ev_nxt      = '0;
        scan_nxt    = CW'(1);
        hit_nxt     = 1'b0;
        rel_any_nxt = 1'b0;
      end
      // Evaluate one slot and read the next.
      ACT_SCAN: begin
        last = (ev_r == AW'(SLOT_COUNT - 1));
        if (op_r == OP_RELALL && ram_rdata != '0 && out_busy) begin
          hold = 1'b1;
        end else begin
          unique case (op_r)
            OP_TRACK: begin
              if (ram_rdata == tid_r) begin
                hit_nxt = 1'b1;
              end
              if (ev_r == ptr_r) begin
                victim_nxt = ram_rdata;
              end
            end
            OP_UNTRACK: begin
              if (ram_rdata == tid_r && ram_rdata != '0) begin
                ram_we  = 1'b1;
                cnt_nxt = cnt_r - CW'(1);
              end
            end
            OP_RELALL: begin
              if (ram_rdata != '0) begin
                ram_we      = 1'b1;
                cnt_nxt     = cnt_r - CW'(1);
                emit        = 1'b1;
                e_rel       = ram_rdata;
                e_rv        = 1'b1;
                e_held      = '0;
                e_last      = (cnt_r == CW'(1));
                rel_any_nxt = 1'b1;
              end
            end
            default: ;
          endcase
          if (!last) begin
            ram_re    = 1'b1;
            ram_raddr = scan_r[AW-1:0];
            ev_nxt    = scan_r[AW-1:0];
            scan_nxt  = scan_r + CW'(1);
          end
        end
      end
      // Final result of the request.
      ACT_FINISH: begin
        emit = !(op_r == OP_RELALL && rel_any_r);
        hold = emit && out_busy;
        if (!hold) begin
          unique case (op_r)
            OP_TRACK: begin
              if (!hit_r) begin
                ram_we    = 1'b1;
                ram_waddr = ptr_r;
                ram_wdata = tid_r;
                ptr_nxt   = (ptr_r == AW'(SLOT_COUNT - 1)) ? '0 : ptr_r + AW'(1);
                if (victim_r != '0) begin
                  e_rel = victim_r;
                  e_rv  = 1'b1;
                  if (tid_r == '0) begin
                    cnt_nxt = cnt_r - CW'(1);
                  end
                end else if (tid_r != '0) begin
                  cnt_nxt = cnt_r + CW'(1);
                end
              end
              e_held = cnt_nxt;
            end
            OP_RELALL: begin
              ptr_nxt = '0;
              e_held  = '0;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign held_x = XW'(e_held);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      cnt_r  <= '0;
      scan_r <= '0;
    end else begin
      ptr_r  <= ptr_nxt;
      cnt_r  <= cnt_nxt;
      scan_r <= scan_nxt;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    tid_r     <= tid_nxt;
    ev_r      <= ev_nxt;
    hit_r     <= hit_nxt;
    victim_r  <= victim_nxt;
    rel_any_r <= rel_any_nxt;
  end

  // Output register: loads a result, clears once the result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit && !hold) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && !hold) begin
      out_rel_r  <= e_rel;
      out_rv_r   <= e_rv;
      out_held_r <= held_x[CountW-1:0];
      out_last_r <= e_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_release_tid   = out_rel_r;
  assign out_release_valid = out_rv_r;
  assign out_held_count    = out_held_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire
